### rtl/core/gpev_pkg.sv
package gpev_pkg;

  // Default number of controllers tracked.
  localparam int NumControllers = 4;

  // Deadzone register reset values.
  localparam logic [14:0] LeftDzReset  = 15'd7849;
  localparam logic [14:0] RightDzReset = 15'd8689;

  // Configuration register indexes.
  localparam logic REG_LEFT_DZ  = 1'b0;
  localparam logic REG_RIGHT_DZ = 1'b1;

  // Event kinds.
  localparam logic [1:0] KIND_CONNECT    = 2'd0;
  localparam logic [1:0] KIND_DISCONNECT = 2'd1;
  localparam logic [1:0] KIND_BUTTON     = 2'd2;
  localparam logic [1:0] KIND_STICK      = 2'd3;

  // Number of watched buttons and the bit each one occupies in the raw word.
  localparam int NumWatched = 10;
  localparam logic [3:0] WatchBit [NumWatched] = '{
    4'd12, 4'd14, 4'd15, 4'd13, 4'd4, 4'd5, 4'd1, 4'd2, 4'd0, 4'd3
  };

  typedef struct packed {
    logic [1:0]         controller;
    logic               read_ok;
    logic [15:0]        buttons;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [1:0]         controller_id;
    logic [3:0]         button_code;
    logic               pressed;
    logic signed [15:0] left_dir_x;
    logic signed [15:0] left_dir_y;
    logic signed [15:0] right_dir_x;
    logic signed [15:0] right_dir_y;
    logic               last;
  } out_item_t;

  // Magnitude of a signed 16-bit value; the most negative value maps to 0x8000.
  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] r;
    r = v[15] ? 16'(-v) : 16'(v);
    return r;
  endfunction

endpackage

### rtl/core/gpev_if.sv
// Input poll channel.
interface gpev_in_if import gpev_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// Event output channel.
interface gpev_out_if import gpev_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// Configuration write channel.
interface gpev_cfg_if;
  logic        valid;
  logic        ready;
  logic        reg_index;
  logic [14:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

### rtl/core/gamepad_button_and_stick_events_unit.sv
// Gamepad button and stick event unit.
// One beat on in_ch is one poll result for one controller. The block answers
// with zero to eleven beats on out_ch: a connect or disconnect event, or, once
// a controller is connected and has seen its first good read, one event per
// changed watched button followed by a stick event; last marks the final beat.
// Deadzone radii are written on cfg (index 0 left, 1 right); the user must
// write them only while idle; the block itself does not enforce it. in_ch.ready
// is high only while the sequencer is idle. A first-read poll gives no event;
// connect and disconnect polls pass through the event state, which loads the
// event. A full poll runs both sticks through one shared 16x16 squarer and one
// 33-bit subtract unit: per stick the squares and the deadzone compare, then,
// with the stick outside the deadzone, per component a square, restoring
// division, square root and a store; then each watched button in turn and the
// stick event. Each event sits in an output register; when the receiver stalls
// the sequencer holds until that register frees, and a new poll is taken as
// soon as the sequencer is back to idle even while the last event still waits.
// Reset clears the connected and initialized flags and restores the deadzone
// defaults; the stored button words carry no reset.
module gamepad_button_and_stick_events_unit import gpev_pkg::*; #(
  parameter int NUM_CONTROLLERS = NumControllers
) (
  input  logic              clk,
  input  logic              rst,
  gpev_in_if.sink           in_ch,
  gpev_out_if.source        out_ch,
  gpev_cfg_if.sink          cfg
);

  localparam int IdxW = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVT   = 4'd1;
  localparam logic [3:0] S_SQX   = 4'd2;
  localparam logic [3:0] S_SQY   = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_AM    = 4'd6;
  localparam logic [3:0] S_DIVI  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_SQI   = 4'd9;
  localparam logic [3:0] S_SQRT  = 4'd10;
  localparam logic [3:0] S_STORE = 4'd11;
  localparam logic [3:0] S_BTN   = 4'd12;
  localparam logic [3:0] S_STK   = 4'd13;

  logic [3:0]  state;
  logic [14:0] left_dz;
  logic [14:0] right_dz;
  logic [NUM_CONTROLLERS-1:0] connected;
  logic [NUM_CONTROLLERS-1:0] initialized;
  logic [15:0] prev_buttons [NUM_CONTROLLERS];

  logic [1:0]  ev_kind;
  logic [1:0]  cid;
  logic [NumWatched-1:0] chg;
  logic [NumWatched-1:0] lvl;
  logic [3:0]  bi;
  logic        sk;
  logic        comp;
  logic signed [15:0] pos [4];
  logic [15:0] dir [4];
  logic [31:0] prod;
  logic [31:0] ssum;
  logic [32:0] rem;
  logic [31:0] op;
  logic [15:0] root;
  logic        tbit;
  logic [4:0]  cnt;

  logic      o_valid;
  out_item_t o_item;

  logic        accept;
  logic        in_range;
  logic [IdxW-1:0] cidx;
  logic        out_free;
  logic        o_load;
  logic [1:0]  idx;
  logic [15:0] mul_in;
  logic [31:0] mul_out;
  logic [32:0] sub_a;
  logic [32:0] sub_b;
  logic [33:0] diff;
  logic        ge;
  logic [15:0] dir_val;
  logic [NumWatched-1:0] chg_now;
  logic [NumWatched-1:0] lvl_now;

  assign in_ch.ready  = (state == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_range     = int'(in_ch.item.controller) < NUM_CONTROLLERS;
  assign cidx         = IdxW'(in_ch.item.controller);
  assign out_free     = !o_valid || out_ch.ready;
  assign out_ch.valid = o_valid;
  assign out_ch.item  = o_item;
  assign cfg.ready    = 1'b1;
  assign idx          = {sk, comp};

  // The output register takes a new event in these states once it is free.
  assign o_load = out_free && (state == S_EVT || state == S_STK ||
                               (state == S_BTN && chg[bi]));

  // Watched-button change and level vectors for the incoming poll.
  always_comb begin
    for (int i = 0; i < NumWatched; i++) begin
      lvl_now[i] = in_ch.item.buttons[WatchBit[i]];
      chg_now[i] = prev_buttons[cidx][WatchBit[i]] ^ in_ch.item.buttons[WatchBit[i]];
    end
  end

  // Shared squarer input selection.
  always_comb begin
    unique case (state)
      S_SQX:   mul_in = mag16(pos[{sk, 1'b0}]);
      S_SQY:   mul_in = mag16(pos[{sk, 1'b1}]);
      S_SUM:   mul_in = {1'b0, (sk ? right_dz : left_dz)};
      default: mul_in = mag16(pos[idx]);
    endcase
  end
  assign mul_out = mul_in * mul_in;

  // Shared subtract and compare unit for division and square root steps.
  always_comb begin
    unique case (state)
      S_DIV: begin
        sub_a = {rem[31:0], tbit};
        sub_b = {1'b0, ssum};
      end
      S_SQRT: begin
        sub_a = {13'd0, rem[17:0], op[31:30]};
        sub_b = {15'd0, root, 2'b01};
      end
      default: begin
        sub_a = rem;
        sub_b = '0;
      end
    endcase
  end
  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = !diff[33];

  // Truncated root with sign restored and positive saturation.
  always_comb begin
    if (pos[idx][15]) begin
      dir_val = 16'(17'd0 - {1'b0, root});
    end else if (root[15]) begin
      dir_val = 16'h7FFF;
    end else begin
      dir_val = root;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= LeftDzReset;
      right_dz <= RightDzReset;
    end else if (cfg.valid) begin
      if (cfg.reg_index == REG_LEFT_DZ) begin
        left_dz <= cfg.wdata;
      end else begin
        right_dz <= cfg.wdata;
      end
    end
  end

  // Stored button words, written on good reads of a connected controller.
  always_ff @(posedge clk) begin
    if (accept && in_range && connected[cidx] && in_ch.item.read_ok) begin
      prev_buttons[cidx] <= in_ch.item.buttons;
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    if (accept) begin
      cid    <= in_ch.item.controller;
      chg    <= chg_now;
      lvl    <= lvl_now;
      pos[0] <= in_ch.item.left_x;
      pos[1] <= in_ch.item.left_y;
      pos[2] <= in_ch.item.right_x;
      pos[3] <= in_ch.item.right_y;
      ev_kind <= connected[cidx] ? KIND_DISCONNECT : KIND_CONNECT;
    end
    unique case (state)
      S_SQX: prod <= mul_out;
      S_SQY: begin
        ssum <= prod;
        prod <= mul_out;
      end
      S_SUM: begin
        ssum <= ssum + prod;
        prod <= mul_out;
      end
      S_CMP: begin
        if (ssum <= prod) begin
          dir[{sk, 1'b0}] <= '0;
          dir[{sk, 1'b1}] <= '0;
        end
      end
      S_AM: prod <= mul_out;
      S_DIVI: begin
        rem  <= {2'd0, prod[31:1]};
        tbit <= prod[0];
        op   <= '0;
        cnt  <= '0;
      end
      S_DIV: begin
        rem  <= ge ? diff[32:0] : sub_a;
        tbit <= 1'b0;
        op   <= {op[30:0], ge};
        cnt  <= cnt + 5'd1;
      end
      S_SQI: begin
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end
      S_SQRT: begin
        rem  <= ge ? diff[32:0] : sub_a;
        root <= {root[14:0], ge};
        op   <= {op[29:0], 2'b00};
        cnt  <= cnt + 5'd1;
      end
      S_STORE: dir[idx] <= dir_val;
      default: ;
    endcase
  end

  // Sequencer, controller flags and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      connected   <= '0;
      initialized <= '0;
      o_valid     <= 1'b0;
      sk          <= 1'b0;
      comp        <= 1'b0;
      bi          <= '0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && in_range) begin
            if (!connected[cidx]) begin
              if (in_ch.item.read_ok) begin
                connected[cidx] <= 1'b1;
                state <= S_EVT;
              end
            end else if (!in_ch.item.read_ok) begin
              connected[cidx] <= 1'b0;
              state <= S_EVT;
            end else if (!initialized[cidx]) begin
              initialized[cidx] <= 1'b1;
            end else begin
              sk    <= 1'b0;
              comp  <= 1'b0;
              state <= S_SQX;
            end
          end
        end
        S_EVT: begin
          if (out_free) begin
            o_item  <= '{event_kind: ev_kind, controller_id: cid, button_code: 4'd0,
                         pressed: 1'b0, left_dir_x: 16'sd0, left_dir_y: 16'sd0,
                         right_dir_x: 16'sd0, right_dir_y: 16'sd0, last: 1'b1};
            state   <= S_IDLE;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: state <= S_SUM;
        S_SUM: state <= S_CMP;
        S_CMP: begin
          if (ssum > prod) begin
            comp  <= 1'b0;
            state <= S_AM;
          end else if (!sk) begin
            sk    <= 1'b1;
            state <= S_SQX;
          end else begin
            bi    <= '0;
            state <= S_BTN;
          end
        end
        S_AM:   state <= S_DIVI;
        S_DIVI: state <= S_DIV;
        S_DIV: begin
          if (cnt == 5'd30) begin
            state <= S_SQI;
          end
        end
        S_SQI: state <= S_SQRT;
        S_SQRT: begin
          if (cnt == 5'd15) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          if (!comp) begin
            comp  <= 1'b1;
            state <= S_AM;
          end else if (!sk) begin
            sk    <= 1'b1;
            comp  <= 1'b0;
            state <= S_SQX;
          end else begin
            bi    <= '0;
            state <= S_BTN;
          end
        end
        S_BTN: begin
          if (!chg[bi] || out_free) begin
            if (chg[bi]) begin
              o_item  <= '{event_kind: KIND_BUTTON, controller_id: cid, button_code: bi,
                           pressed: lvl[bi], left_dir_x: 16'sd0, left_dir_y: 16'sd0,
                           right_dir_x: 16'sd0, right_dir_y: 16'sd0, last: 1'b0};
            end
            if (bi == 4'(NumWatched - 1)) begin
              state <= S_STK;
            end else begin
              bi <= bi + 4'd1;
            end
          end
        end
        S_STK: begin
          if (out_free) begin
            o_item  <= '{event_kind: KIND_STICK, controller_id: cid, button_code: 4'd0,
                         pressed: 1'b0, left_dir_x: dir[0], left_dir_y: dir[1],
                         right_dir_x: dir[2], right_dir_y: dir[3], last: 1'b1};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Button events never close a poll's run of events.
  a_button_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.item.event_kind == KIND_BUTTON) |-> !out_ch.item.last)
    else $error("button event marked last");

  // Connect and disconnect events always stand alone.
  a_link_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.item.event_kind == KIND_CONNECT ||
     out_ch.item.event_kind == KIND_DISCONNECT)) |-> out_ch.item.last)
    else $error("connect or disconnect event not last");

  // A poll accepted on a connected controller with a failed read drops the link.
  a_disconnect: assert property (@(posedge clk) disable iff (rst)
    (accept && in_range && connected[cidx] && !in_ch.item.read_ok)
    |=> (state == S_EVT && ev_kind == KIND_DISCONNECT))
    else $error("failed read did not start a disconnect event");
`endif

endmodule
